FILE: sv/lfas_pkg.sv
// shared types and constants for the lazy-flag add and interrupt sampler
// no dependencies

package lfas_pkg;

  typedef enum logic [1:0] {
    CMD_ADD      = 2'd0,
    CMD_SAMPLE   = 2'd1,
    CMD_BOUNDARY = 2'd2
  } cmd_e;

  // cc bit positions
  localparam int unsigned CcCBit = 0;
  localparam int unsigned CcVBit = 1;
  localparam int unsigned CcZBit = 2;
  localparam int unsigned CcNBit = 3;
  localparam int unsigned CcIBit = 4;
  localparam int unsigned CcHBit = 5;
  localparam int unsigned CcFBit = 6;

  localparam logic [7:0] CcFlagMask = 8'h2F;

  // control pin positions
  localparam int unsigned PinNmi  = 0;
  localparam int unsigned PinIrq  = 1;
  localparam int unsigned PinFirq = 2;
  localparam int unsigned PinHalt = 3;

  // one word being processed in the execute stage
  typedef struct packed {
    logic fire;
    logic is_add;
    logic is_boundary;
  } step_t;

  typedef struct packed {
    logic nmi;
    logic irq;
    logic firq;
    logic halt;
  } pend_t;

endpackage

FILE: sv/lfas_add_unit.sv
// accumulator a adder with lazy condition code state
// depends on lfas_pkg

module lfas_add_unit import lfas_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  step_t      step_i,
  input  logic [7:0] data_byte_i,
  input  logic [7:0] cc_in_i,
  output logic [7:0] acc_a_o,
  output logic [7:0] cc_out_o
);

  logic [7:0] acc_q, acc_d;
  logic [7:0] left_q, left_d;
  logic [7:0] right_q, right_d;
  logic [8:0] raw_q, raw_d;
  logic [8:0] half_x;
  logic [7:0] ovf_x;
  logic [7:0] flags;

  always_comb begin
    acc_d   = acc_q;
    left_d  = left_q;
    right_d = right_q;
    raw_d   = raw_q;
    if (step_i.fire && step_i.is_add) begin
      left_d  = acc_q;
      right_d = data_byte_i;
      raw_d   = {1'b0, acc_q} + {1'b0, data_byte_i};
      acc_d   = raw_d[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      left_q  <= '0;
      right_q <= '0;
      raw_q   <= '0;
    end else begin
      acc_q   <= acc_d;
      left_q  <= left_d;
      right_q <= right_d;
      raw_q   <= raw_d;
    end
  end

  // flags come from the state after this word
  always_comb begin
    half_x = {1'b0, left_d} ^ {1'b0, right_d} ^ raw_d;
    ovf_x  = (left_d ^ raw_d[7:0]) & (right_d ^ raw_d[7:0]);
    flags  = '0;
    flags[CcCBit] = raw_d[8];
    flags[CcVBit] = ovf_x[7];
    flags[CcZBit] = (raw_d[7:0] == 8'h00);
    flags[CcNBit] = raw_d[7];
    flags[CcHBit] = half_x[4];
  end

  assign acc_a_o  = acc_d;
  assign cc_out_o = (cc_in_i & ~CcFlagMask) | flags;

endmodule

FILE: sv/lfas_irq_unit.sv
// control line capture and pending event decode
// depends on lfas_pkg

module lfas_irq_unit import lfas_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  step_t      step_i,
  input  logic [3:0] ctrl_pins_n_i,
  input  logic [7:0] cc_in_i,
  output pend_t      pend_o
);

  logic [3:0] lines_q, lines_d;
  logic [3:0] prev_q, prev_d;
  logic [3:0] seen;

  always_comb begin
    seen    = lines_q | ~ctrl_pins_n_i;
    lines_d = lines_q;
    prev_d  = prev_q;
    pend_o  = '0;
    if (step_i.fire) begin
      lines_d = seen;
      if (step_i.is_boundary) begin
        pend_o.nmi  = seen[PinNmi] & ~prev_q[PinNmi];
        pend_o.irq  = seen[PinIrq] & ~cc_in_i[CcIBit];
        pend_o.firq = seen[PinFirq] & ~cc_in_i[CcFBit];
        pend_o.halt = seen[PinHalt];
        prev_d      = seen;
        lines_d     = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lines_q <= '0;
      prev_q  <= '0;
    end else begin
      lines_q <= lines_d;
      prev_q  <= prev_d;
    end
  end

endmodule

FILE: sv/lazy_flag_add_and_interrupt_sampler_top.sv
// lazy-flag accumulator a adder with interrupt line sampler
// path: an accepted word passes through the input register, then the result register
// throughput: one word per cycle while the output is not stalled, set by the single execute stage
// reset: async active low, clears a, lazy flag state, line capture and valids
// depends on lfas_pkg, lfas_add_unit, lfas_irq_unit

module lazy_flag_add_and_interrupt_sampler_top import lfas_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] command_i,
  input  logic [7:0] data_byte_i,
  input  logic [3:0] ctrl_pins_n_i,
  input  logic [7:0] cc_in_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] acc_a_o,
  output logic [7:0] cc_out_o,
  output logic       nmi_pending_o,
  output logic       irq_pending_o,
  output logic       firq_pending_o,
  output logic       halt_pending_o
);

  logic       in_valid_q;
  logic [1:0] cmd_q;
  logic [7:0] data_q;
  logic [3:0] pins_q;
  logic [7:0] cc_q;
  logic       out_valid_q;
  logic [7:0] acc_q;
  logic [7:0] cc_out_q;
  pend_t      pend_q;

  logic       advance;
  logic       in_fire;
  step_t      step;
  logic [7:0] acc_w;
  logic [7:0] cc_w;
  pend_t      pend_w;

  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = in_valid_q && !advance;
  assign in_fire    = in_valid_i && !in_stall_o;

  always_comb begin
    step.fire        = in_valid_q && advance;
    step.is_add      = (cmd_q == CMD_ADD);
    step.is_boundary = (cmd_q == CMD_BOUNDARY);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q  <= command_i;
      data_q <= data_byte_i;
      pins_q <= ctrl_pins_n_i;
      cc_q   <= cc_in_i;
    end
    if (step.fire) begin
      acc_q    <= acc_w;
      cc_out_q <= cc_w;
      pend_q   <= pend_w;
    end
  end

  lfas_add_unit u_add (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .data_byte_i (data_q),
    .cc_in_i     (cc_q),
    .acc_a_o     (acc_w),
    .cc_out_o    (cc_w)
  );

  lfas_irq_unit u_irq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .ctrl_pins_n_i (pins_q),
    .cc_in_i       (cc_q),
    .pend_o        (pend_w)
  );

  assign out_valid_o    = out_valid_q;
  assign acc_a_o        = acc_q;
  assign cc_out_o       = cc_out_q;
  assign nmi_pending_o  = pend_q.nmi;
  assign irq_pending_o  = pend_q.irq;
  assign firq_pending_o = pend_q.firq;
  assign halt_pending_o = pend_q.halt;

endmodule

FILE: sv/lfas_checker.sv
// port-level checks for the lazy-flag add and interrupt sampler
// depends on lfas_pkg and lazy_flag_add_and_interrupt_sampler_top (bound below)

module lfas_checker import lfas_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] acc_a_o,
  input logic [7:0] cc_out_o,
  input logic       irq_pending_o,
  input logic       firq_pending_o
);

  // no word is offered while reset is held
  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("result valid during reset");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(acc_a_o) && $stable(cc_out_o))
    else $error("stalled result word changed");

  // z and n always agree with a, since a equals the low byte of the lazy raw sum
  a_zn_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (cc_out_o[CcZBit] == (acc_a_o == 8'h00)) &&
                    (cc_out_o[CcNBit] == acc_a_o[7]))
    else $error("z or n flag disagrees with accumulator a");

  a_irq_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && irq_pending_o |-> !cc_out_o[CcIBit])
    else $error("irq pending while masked");

  a_firq_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && firq_pending_o |-> !cc_out_o[CcFBit])
    else $error("firq pending while masked");

endmodule

bind lazy_flag_add_and_interrupt_sampler_top lfas_checker u_lfas_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .acc_a_o        (acc_a_o),
  .cc_out_o       (cc_out_o),
  .irq_pending_o  (irq_pending_o),
  .firq_pending_o (firq_pending_o)
);

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// self-checking bench for the lazy-flag add and interrupt sampler: directed table, then random
// bus cycles under varying idle/stall pressure; depends on lfas_pkg and the top-level rtl

module tb_top;
  import lfas_pkg::*;

  localparam logic [1:0]  CmdUnused  = 2'd3;
  localparam int unsigned NumDir     = 22;
  localparam int unsigned PhaseWords = 250;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned MaxReports = 10;

  typedef struct packed {
    logic [7:0] acc;
    logic [7:0] cc;
    logic       nmi;
    logic       irq;
    logic       firq;
    logic       halt;
  } result_t;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] data;
    logic [3:0] pins_n;
    logic [7:0] cc;
    logic       chk;
    result_t    exp;
  } stim_row_t;

  logic       clk_i = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [1:0] command;
  logic [7:0] data_byte;
  logic [3:0] ctrl_pins_n;
  logic [7:0] cc_in;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] acc_a;
  logic [7:0] cc_out;
  logic       nmi_pending;
  logic       irq_pending;
  logic       firq_pending;
  logic       halt_pending;

  // predictor state
  logic [7:0] acc_q;
  logic [7:0] lhs_q;
  logic [7:0] rhs_q;
  logic [8:0] sum_q;
  logic [3:0] lines_seen_q;
  logic [3:0] lines_prev_q;

  result_t     predicted_outputs[$];
  stim_row_t   dir_rows [NumDir];
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int unsigned errors        = 0;
  int unsigned words_sent    = 0;
  int unsigned words_checked = 0;
  int unsigned boundaries    = 0;
  int unsigned cycles        = 0;

  lazy_flag_add_and_interrupt_sampler_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .command_i     (command),
    .data_byte_i   (data_byte),
    .ctrl_pins_n_i (ctrl_pins_n),
    .cc_in_i       (cc_in),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .acc_a_o       (acc_a),
    .cc_out_o      (cc_out),
    .nmi_pending_o (nmi_pending),
    .irq_pending_o (irq_pending),
    .firq_pending_o(firq_pending),
    .halt_pending_o(halt_pending)
  );

  always #1 clk_i = ~clk_i;

  // one bus cycle of the add unit and line sampler, updating the predictor state
  function automatic result_t bus_cycle_result(stim_row_t w);
    result_t r;
    r = '0;
    if (w.command == CMD_ADD) begin
      lhs_q = acc_q;
      rhs_q = w.data;
      sum_q = {1'b0, acc_q} + {1'b0, w.data};
      acc_q = sum_q[7:0];
    end
    lines_seen_q = lines_seen_q | ~w.pins_n;
    if (w.command == CMD_BOUNDARY) begin
      r.nmi  = lines_seen_q[PinNmi] & ~lines_prev_q[PinNmi];
      r.irq  = lines_seen_q[PinIrq] & ~w.cc[CcIBit];
      r.firq = lines_seen_q[PinFirq] & ~w.cc[CcFBit];
      r.halt = lines_seen_q[PinHalt];
      lines_prev_q = lines_seen_q;
      lines_seen_q = '0;
    end
    r.acc = acc_q;
    r.cc  = w.cc & ~CcFlagMask;
    r.cc[CcCBit] = sum_q[8];
    r.cc[CcVBit] = (lhs_q[7] ^ sum_q[7]) & (rhs_q[7] ^ sum_q[7]);
    r.cc[CcZBit] = (sum_q[7:0] == 8'h00);
    r.cc[CcNBit] = sum_q[7];
    r.cc[CcHBit] = lhs_q[4] ^ rhs_q[4] ^ sum_q[4];
    return r;
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic send_word(input stim_row_t w);
    result_t pred;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid    <= 1'b1;
    command     <= w.command;
    data_byte   <= w.data;
    ctrl_pins_n <= w.pins_n;
    cc_in       <= w.cc;
    do @(posedge clk_i); while (in_stall);
    pred = bus_cycle_result(w);
    predicted_outputs.push_back(w.chk ? w.exp : pred);
    words_sent++;
    if (w.command == CMD_BOUNDARY) boundaries++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk_i);
    while (predicted_outputs.size() != 0) @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin
    result_t e;
    if (rst_n && out_valid && !out_stall) begin
      words_checked++;
      if (predicted_outputs.size() == 0) begin
        errors++;
        if (errors <= MaxReports) $display("unexpected word: acc %h cc %h", acc_a, cc_out);
      end else begin
        e = predicted_outputs.pop_front();
        if (acc_a !== e.acc || cc_out !== e.cc || nmi_pending !== e.nmi ||
            irq_pending !== e.irq || firq_pending !== e.firq || halt_pending !== e.halt) begin
          errors++;
          if (errors <= MaxReports) begin
            $display("mismatch: acc %h/%h cc %h/%h nmi %b/%b irq %b/%b firq %b/%b halt %b/%b",
                     e.acc, acc_a, e.cc, cc_out, e.nmi, nmi_pending, e.irq, irq_pending,
                     e.firq, firq_pending, e.halt, halt_pending);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycles,
               predicted_outputs.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    stim_row_t w;
    int unsigned pick;

    // command       data   pins  cc     chk   acc    cc     n,i,f,h
    dir_rows = '{
      {CMD_SAMPLE,   8'h00, 4'hF, 8'h00, 1'b1, 8'h00, 8'h04, 4'b0000}, // zero flags after reset
      {CMD_BOUNDARY, 8'h00, 4'hF, 8'hFF, 1'b1, 8'h00, 8'hD4, 4'b0000}, // e/f/i pass through
      {CMD_ADD,      8'hFF, 4'hF, 8'h00, 1'b1, 8'hFF, 8'h08, 4'b0000},
      {CMD_ADD,      8'h01, 4'hF, 8'hFF, 1'b1, 8'h00, 8'hF5, 4'b0000}, // carry, half carry, zero
      {CMD_ADD,      8'h7F, 4'hF, 8'h00, 1'b1, 8'h7F, 8'h00, 4'b0000},
      {CMD_ADD,      8'h01, 4'hF, 8'h00, 1'b1, 8'h80, 8'h2A, 4'b0000}, // signed overflow
      {CMD_ADD,      8'h80, 4'hF, 8'h00, 1'b1, 8'h00, 8'h07, 4'b0000},
      {CMD_SAMPLE,   8'hFF, 4'h0, 8'h00, 1'b1, 8'h00, 8'h07, 4'b0000}, // all lines low
      {CMD_BOUNDARY, 8'h00, 4'hF, 8'h00, 1'b1, 8'h00, 8'h07, 4'b1111},
      {CMD_BOUNDARY, 8'h00, 4'h0, 8'h50, 1'b1, 8'h00, 8'h57, 4'b0001}, // masked, no new nmi edge
      {CMD_BOUNDARY, 8'h00, 4'hF, 8'h00, 1'b1, 8'h00, 8'h07, 4'b0000},
      {CMD_BOUNDARY, 8'h00, 4'hE, 8'h00, 1'b1, 8'h00, 8'h07, 4'b1000},
      {CmdUnused,    8'hAA, 4'hE, 8'h00, 1'b1, 8'h00, 8'h07, 4'b0000}, // unused code samples
      {CMD_BOUNDARY, 8'h00, 4'hF, 8'h00, 1'b1, 8'h00, 8'h07, 4'b0000}, // nmi held, no edge
      {CMD_ADD,      8'h5A, 4'h0, 8'hAA, 1'b0, 8'h00, 8'h00, 4'b0000},
      {CMD_BOUNDARY, 8'h00, 4'hD, 8'h10, 1'b0, 8'h00, 8'h00, 4'b0000},
      {CMD_BOUNDARY, 8'h00, 4'hB, 8'h40, 1'b0, 8'h00, 8'h00, 4'b0000},
      {CMD_BOUNDARY, 8'h00, 4'h9, 8'h00, 1'b0, 8'h00, 8'h00, 4'b0000},
      {CMD_ADD,      8'h06, 4'hF, 8'h00, 1'b0, 8'h00, 8'h00, 4'b0000},
      {CMD_ADD,      8'h00, 4'hF, 8'h80, 1'b0, 8'h00, 8'h00, 4'b0000},
      {CMD_SAMPLE,   8'h00, 4'h7, 8'hFF, 1'b0, 8'h00, 8'h00, 4'b0000},
      {CMD_BOUNDARY, 8'h00, 4'hF, 8'hFF, 1'b0, 8'h00, 8'h00, 4'b0000}
    };

    acc_q = '0;
    lhs_q = '0;
    rhs_q = '0;
    sum_q = '0;
    lines_seen_q = '0;
    lines_prev_q = '0;

    rst_n       = 1'b0;
    in_valid    = 1'b0;
    command     = CMD_SAMPLE;
    data_byte   = '0;
    ctrl_pins_n = 4'hF;
    cc_in       = '0;
    repeat (3) @(negedge clk_i);
    rst_n <= 1'b1;
    @(negedge clk_i);

    send_idle_pct = 22;
    stall_pct     = 74;
    foreach (dir_rows[i]) send_word(dir_rows[i]);
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 22 : (ph == 1) ? 74 : 0;
      stall_pct     = (ph == 0) ? 74 : (ph == 1) ? 22 : 0;
      for (int n = 0; n < PhaseWords; n++) begin
        w = '0;
        pick = $urandom_range(99);
        w.command = (pick < 45) ? CMD_ADD : (pick < 70) ? CMD_SAMPLE :
                    (pick < 95) ? CMD_BOUNDARY : CmdUnused;
        pick = $urandom_range(7);
        case (pick)
          0: w.data = 8'h00;
          1: w.data = 8'hFF;
          2: w.data = 8'h7F + 8'($urandom_range(1));
          default: w.data = 8'($urandom);
        endcase
        // lines mostly idle so that edges and single requests stand out
        pick = $urandom_range(9);
        if (pick < 6) w.pins_n = 4'hF;
        else if (pick < 9) w.pins_n = ~(4'b0001 << $urandom_range(3));
        else w.pins_n = 4'($urandom);
        w.cc = 8'($urandom);
        send_word(w);
      end
      // let the pipe run dry before the next phase
      drain();
    end

    repeat (8) @(posedge clk_i);
    $display("%0d bus cycles sent (%0d boundaries), %0d result words checked, %0d errors",
             words_sent, boundaries, words_checked, errors);
    if (errors == 0 && predicted_outputs.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
